### rtl/lppp_pkg.sv
package lppp_pkg;

  localparam int SqW      = 24;
  localparam int RadW     = 48;
  localparam int RemW     = 26;
  localparam int CordW    = 27;
  localparam int AngW     = 27;

  localparam logic signed [AngW-1:0] Deg90  = 27'sd5898240;
  localparam logic signed [AngW-1:0] Deg180 = 27'sd11796480;
  localparam logic signed [AngW-1:0] Deg360 = 27'sd23592960;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]         reflectance;
  } point_t;

  typedef struct packed {
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_col;
    logic [15:0] range_cm;
    logic [7:0]  reflect_out;
    logic        point_valid;
  } result_t;

  typedef struct packed {
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [SqW-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic signed [CordW-1:0] a;
    logic signed [CordW-1:0] b;
    logic signed [AngW-1:0]  acc;
    logic                    skip;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic cord_t cordic_init(input logic signed [CordW-1:0] a,
                                        input logic signed [CordW-1:0] b);
    cord_t c;
    c.a    = a;
    c.b    = b;
    c.acc  = '0;
    c.skip = 1'b0;
    if (b == '0) begin
      c.acc  = (a >= 0) ? '0 : Deg180;
      c.skip = 1'b1;
    end else if (a == '0) begin
      c.acc  = (b > 0) ? Deg90 : -Deg90;
      c.skip = 1'b1;
    end else if (a < 0) begin
      c.acc = (b >= 0) ? Deg180 : -Deg180;
      c.a   = -a;
      c.b   = -b;
    end
    return c;
  endfunction

endpackage

### rtl/lidar_point_polar_projection.sv
// channel  | ports                      | transaction
// ---------+----------------------------+----------------------------------
// point    | start, busy, point_i       | start high while busy low
// result   | result_valid_o, result_o   | one cycle with result_valid_o high
//
// One point per cycle; busy stays low.
// The pipeline is two squaring stages, 24 square-root
// cells, one setup stage, ANGLE_STAGES CORDIC cells and one output stage.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall; each result is shown for one cycle.
module lidar_point_polar_projection #(
  parameter int unsigned ANGLE_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lppp_pkg::point_t  point_i,
  output logic              result_valid_o,
  output lppp_pkg::result_t result_o
);
  import lppp_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         refl;
    logic               nz;
  } side_t;

  typedef struct packed {
    logic [15:0] range;
    logic [7:0]  refl;
    logic        nz;
  } cside_t;

  logic        accept_w;
  logic        s1_vld_q;
  side_t       s1_side_q;
  logic [31:0] xx_q, yy_q, zz_q;
  logic        s2_vld_q;
  side_t       s2_side_q;
  logic [31:0] hsq_q, rsq_q;

  sq_t    sqh [0:SqW];
  sq_t    sqr [0:SqW];
  side_t  sside_q [0:SqW];
  logic   svld_q [0:SqW];

  cord_t  cz [0:ANGLE_STAGES];
  cord_t  ca [0:ANGLE_STAGES];
  cside_t cside_q [0:ANGLE_STAGES];
  logic   cvld_q [0:ANGLE_STAGES];

  cord_t  elev_init_w, azim_init_w;
  cord_t  cz_q, ca_q;

  logic signed [AngW-1:0] elev_w, azim_w;
  logic signed [10:0]     row_full_w;
  result_t                res_d;

  assign busy     = 1'b0;
  assign accept_w = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_w;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q.x    <= point_i.point_x;
    s1_side_q.y    <= point_i.point_y;
    s1_side_q.z    <= point_i.point_z;
    s1_side_q.refl <= point_i.reflectance;
    s1_side_q.nz   <= (point_i.point_x != '0) || (point_i.point_y != '0) ||
                      (point_i.point_z != '0);
    xx_q           <= 32'(point_i.point_x * point_i.point_x);
    yy_q           <= 32'(point_i.point_y * point_i.point_y);
    zz_q           <= 32'(point_i.point_z * point_i.point_z);
    s2_side_q      <= s1_side_q;
    hsq_q          <= xx_q + yy_q;
    rsq_q          <= xx_q + yy_q + zz_q;
  end

  assign sqh[0] = '{rad: {hsq_q, 16'b0}, rem: '0, root: '0};
  assign sqr[0] = '{rad: {rsq_q, 16'b0}, rem: '0, root: '0};

  always_comb begin
    sside_q[0] = s2_side_q;
    svld_q[0]  = s2_vld_q;
  end

  for (genvar k = 0; k < SqW; k++) begin : g_sqrt
    lppp_sqrt_cell u_h (.clk_i(clk_i), .lane_i(sqh[k]), .lane_o(sqh[k+1]));
    lppp_sqrt_cell u_r (.clk_i(clk_i), .lane_i(sqr[k]), .lane_o(sqr[k+1]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[k+1] <= 1'b0;
      end else begin
        svld_q[k+1] <= svld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sside_q[k+1] <= sside_q[k];
    end
  end

  always_comb begin
    elev_init_w     = cordic_init({{3{sside_q[SqW].z[15]}}, sside_q[SqW].z, 8'b0},
                                  {3'b0, sqh[SqW].root});
    azim_init_w     = cordic_init({{3{sside_q[SqW].x[15]}}, sside_q[SqW].x, 8'b0},
                                  {{3{sside_q[SqW].y[15]}}, sside_q[SqW].y, 8'b0});
    azim_init_w.acc = azim_init_w.acc + Deg180;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q[0] <= 1'b0;
    end else begin
      cvld_q[0] <= svld_q[SqW];
    end
  end

  always_ff @(posedge clk_i) begin
    cz_q             <= elev_init_w;
    ca_q             <= azim_init_w;
    cside_q[0].range <= sqr[SqW].root[SqW-1 -: 16];
    cside_q[0].refl  <= sside_q[SqW].refl;
    cside_q[0].nz    <= sside_q[SqW].nz;
  end

  assign cz[0] = cz_q;
  assign ca[0] = ca_q;

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cordic
    lppp_cordic_cell #(.Shift(k)) u_e (.clk_i(clk_i), .lane_i(cz[k]), .lane_o(cz[k+1]));
    lppp_cordic_cell #(.Shift(k)) u_a (.clk_i(clk_i), .lane_i(ca[k]), .lane_o(ca[k+1]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cvld_q[k+1] <= 1'b0;
      end else begin
        cvld_q[k+1] <= cvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      cside_q[k+1] <= cside_q[k];
    end
  end

  always_comb begin
    elev_w     = cz[ANGLE_STAGES].acc;
    azim_w     = ca[ANGLE_STAGES].acc;
    row_full_w = 11'(elev_w >>> 16);
    if (azim_w < 0) begin
      azim_w = azim_w + Deg360;
    end else if (azim_w >= Deg360) begin
      azim_w = azim_w - Deg360;
    end
    res_d.reflect_out = cside_q[ANGLE_STAGES].refl;
    res_d.point_valid = cside_q[ANGLE_STAGES].nz;
    res_d.range_cm    = cside_q[ANGLE_STAGES].range;
    res_d.pixel_col   = azim_w[24:16];
    if (row_full_w < 0) begin
      res_d.pixel_row = '0;
    end else if (row_full_w > 11'sd180) begin
      res_d.pixel_row = 8'd180;
    end else begin
      res_d.pixel_row = row_full_w[7:0];
    end
    if (!cside_q[ANGLE_STAGES].nz) begin
      res_d.pixel_row = '0;
      res_d.pixel_col = '0;
      res_d.range_cm  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cvld_q[ANGLE_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end
endmodule

### rtl/lppp_sqrt_cell.sv
module lppp_sqrt_cell (
  input  logic          clk_i,
  input  lppp_pkg::sq_t lane_i,
  output lppp_pkg::sq_t lane_o
);
  import lppp_pkg::*;

  logic [RemW-1:0] rem_w;
  logic [RemW-1:0] trial_w;
  sq_t             lane_d;
  sq_t             lane_q;

  always_comb begin
    rem_w      = {lane_i.rem[RemW-3:0], lane_i.rad[RadW-1 -: 2]};
    trial_w    = {lane_i.root, 2'b01};
    lane_d.rad = {lane_i.rad[RadW-3:0], 2'b00};
    if (rem_w >= trial_w) begin
      lane_d.rem  = rem_w - trial_w;
      lane_d.root = {lane_i.root[SqW-2:0], 1'b1};
    end else begin
      lane_d.rem  = rem_w;
      lane_d.root = {lane_i.root[SqW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;
endmodule

### rtl/lppp_cordic_cell.sv
module lppp_cordic_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic            clk_i,
  input  lppp_pkg::cord_t lane_i,
  output lppp_pkg::cord_t lane_o
);
  import lppp_pkg::*;

  logic signed [CordW-1:0] da_w;
  logic signed [CordW-1:0] db_w;
  logic signed [AngW-1:0]  step_w;
  cord_t                   lane_d;
  cord_t                   lane_q;

  always_comb begin
    da_w   = lane_i.b >>> Shift;
    db_w   = lane_i.a >>> Shift;
    step_w = atan_q16(5'(Shift));
    lane_d = lane_i;
    if (!lane_i.skip) begin
      if (lane_i.b >= 0) begin
        lane_d.a   = lane_i.a + da_w;
        lane_d.b   = lane_i.b - db_w;
        lane_d.acc = lane_i.acc + step_w;
      end else begin
        lane_d.a   = lane_i.a - da_w;
        lane_d.b   = lane_i.b + db_w;
        lane_d.acc = lane_i.acc - step_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;
endmodule

### rtl/lppp_checker.sv
module lppp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy,
  input logic              result_valid_o,
  input lppp_pkg::result_t result_o
);
  import lppp_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.point_valid) |->
      (result_o.pixel_row == '0 && result_o.pixel_col == '0 && result_o.range_cm == '0))
    else $error("origin point with nonzero fields");

  a_range_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.point_valid) |-> (result_o.range_cm != '0))
    else $error("valid point with zero range");

  a_cell_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.pixel_row <= 8'd180 && result_o.pixel_col <= 9'd359))
    else $error("pixel out of image");
endmodule

bind lidar_point_polar_projection lppp_checker u_lppp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .busy(busy),
  .result_valid_o(result_valid_o),
  .result_o(result_o)
);
